### src/itoa_fmt_pkg.sv
// Shared types, constants and a helper function for the integer to ASCII formatter.
package itoa_fmt_pkg;

  // Width of the pointer in pointer hex mode.
  localparam int unsigned PointerBits = 64;
  // Hex digits that cover one pointer.
  localparam int unsigned PtrDigits   = (PointerBits + 3) / 4;
  // Left shift that puts the top pointer digit in the top nibble.
  localparam int unsigned PtrShift    = 64 - 4 * PtrDigits;
  // Mask that keeps the pointer bits of the value.
  localparam logic [63:0] PtrMask     = {64{1'b1}} >> (64 - PointerBits);

  // Binary width of the decimal modes, and the BCD digits that it needs.
  localparam int unsigned DecBits     = 32;
  localparam int unsigned DecDigits   = 10;
  localparam int unsigned BcdBits     = 4 * DecDigits;
  localparam int unsigned DecCntW     = $clog2(DecBits);
  localparam int unsigned HexDigits   = DecBits / 4;

  // Width of a digit or character count (holds up to 16).
  localparam int unsigned CountW      = 5;

  // ASCII codes.
  localparam logic [6:0] AsciiZero    = 7'h30;
  localparam logic [6:0] AsciiLowerA  = 7'h61;
  localparam logic [6:0] AsciiUpperA  = 7'h41;
  localparam logic [6:0] AsciiMinus   = 7'h2d;

  // Format modes.
  typedef enum logic [2:0] {
    ModeSignedDec   = 3'd0,
    ModeUnsignedDec = 3'd1,
    ModeHexLower    = 3'd2,
    ModeHexUpper    = 3'd3,
    ModePointerHex  = 3'd4
  } mode_e;

  // Input request: one number and its mode.
  typedef struct packed {
    logic [2:0]  mode;
    logic [63:0] value;
  } in_req_t;

  // Output request: one character.
  typedef struct packed {
    logic [6:0]        char_code;
    logic              last;
    logic [CountW-1:0] char_count;
  } out_req_t;

  // Turns one digit into its ASCII character.
  function automatic logic [6:0] digit_char(input logic [3:0] digit, input logic upper);
    logic [6:0] base;
    base = upper ? AsciiUpperA : AsciiLowerA;
    if (digit < 4'd10) begin
      return AsciiZero + {3'b000, digit};
    end else begin
      return base + {3'b000, digit} - 7'd10;
    end
  endfunction

endpackage

### src/integer_to_ascii_formatter_unit.sv
// Top level of the integer to ASCII formatter: shift-add BCD converter and serial emitter.
//
//  Channel | Direction | Payload                        | Handshake
//  --------+-----------+--------------------------------+------------------------
//  in      | input     | in_req_i  (mode, value)        | in_valid_i / in_stall_o
//  out     | output    | out_req_o (char, last, count)  | out_valid_o / out_stall_i
//
// A decimal number is accepted, converted by the shift-add loop on the BCD adjust unit,
// stripped of leading zero digits one at a time and then handed to the emitter, which
// sends one character per cycle while the output is not stalled.
// A hex number (32-bit or pointer) skips the shift-add pass: its leading zero digits are
// dropped one at a time before the emitter starts, which then sends characters as above.
// An unused mode is accepted and dropped without leaving idle.
// Reset returns the sequencer to idle and empties the output register.
// An output stall holds the emitter; the input side stalls until the last character
// of the number has been loaded into the output register.
module integer_to_ascii_formatter_unit (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  itoa_fmt_pkg::in_req_t  in_req_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output itoa_fmt_pkg::out_req_t out_req_o
);

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StConv = 4'b0010,
    StSkip = 4'b0100,
    StEmit = 4'b1000
  } state_e;

  localparam int unsigned CntW = itoa_fmt_pkg::DecCntW;
  localparam int unsigned CW   = itoa_fmt_pkg::CountW;

  state_e                                  state_q, state_d;
  logic [63:0]                             digits_q, digits_d;
  logic [itoa_fmt_pkg::DecBits-1:0]        bin_q, bin_d;
  logic [CntW-1:0]                         cnt_q, cnt_d;
  logic [CW-1:0]                           ndig_q, ndig_d;
  logic [CW-1:0]                           total_q, total_d;
  logic                                    sign_q, sign_d;
  logic                                    upper_q, upper_d;
  logic                                    out_valid_q, out_valid_d;
  itoa_fmt_pkg::out_req_t                  out_q, out_d;

  logic                                    in_accept;
  logic                                    out_free;
  logic [itoa_fmt_pkg::DecBits-1:0]        dec_mag;
  logic [itoa_fmt_pkg::BcdBits-1:0]        bcd_adj;
  logic [itoa_fmt_pkg::BcdBits-1:0]        bcd_next;
  logic                                    emit_last;

  assign in_accept = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;

  // Magnitude of the low word; negated only for a negative signed number.
  always_comb begin
    if ((in_req_i.mode == itoa_fmt_pkg::ModeSignedDec) && in_req_i.value[31]) begin
      dec_mag = itoa_fmt_pkg::DecBits'(0) - in_req_i.value[itoa_fmt_pkg::DecBits-1:0];
    end else begin
      dec_mag = in_req_i.value[itoa_fmt_pkg::DecBits-1:0];
    end
  end

  // BCD adjust unit: add three to every digit of five or more, then shift in one bit.
  always_comb begin
    for (int i = 0; i < itoa_fmt_pkg::DecDigits; i++) begin
      if (digits_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = digits_q[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = digits_q[4*i +: 4];
      end
    end
    bcd_next = {bcd_adj[itoa_fmt_pkg::BcdBits-2:0], bin_q[itoa_fmt_pkg::DecBits-1]};
  end

  assign emit_last = (ndig_q == CW'(1));

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    digits_d    = digits_q;
    bin_d       = bin_q;
    cnt_d       = cnt_q;
    ndig_d      = ndig_q;
    total_d     = total_q;
    sign_d      = sign_q;
    upper_d     = upper_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;

    unique case (state_q)
      StIdle: begin
        if (in_accept) begin
          sign_d  = 1'b0;
          upper_d = 1'b0;
          cnt_d   = '0;
          unique case (in_req_i.mode)
            itoa_fmt_pkg::ModeSignedDec, itoa_fmt_pkg::ModeUnsignedDec: begin
              sign_d   = (in_req_i.mode == itoa_fmt_pkg::ModeSignedDec) && in_req_i.value[31];
              bin_d    = dec_mag;
              digits_d = '0;
              ndig_d   = CW'(itoa_fmt_pkg::DecDigits);
              state_d  = StConv;
            end
            itoa_fmt_pkg::ModeHexLower, itoa_fmt_pkg::ModeHexUpper: begin
              upper_d  = (in_req_i.mode == itoa_fmt_pkg::ModeHexUpper);
              digits_d = {in_req_i.value[31:0], 32'b0};
              ndig_d   = CW'(itoa_fmt_pkg::HexDigits);
              state_d  = StSkip;
            end
            itoa_fmt_pkg::ModePointerHex: begin
              digits_d = (in_req_i.value & itoa_fmt_pkg::PtrMask) << itoa_fmt_pkg::PtrShift;
              ndig_d   = CW'(itoa_fmt_pkg::PtrDigits);
              state_d  = StSkip;
            end
            default: begin
              state_d = StIdle;
            end
          endcase
        end
      end
      StConv: begin
        bin_d = {bin_q[itoa_fmt_pkg::DecBits-2:0], 1'b0};
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(itoa_fmt_pkg::DecBits - 1)) begin
          // Left-align the finished BCD digits for the emitter.
          digits_d = {bcd_next, (64 - itoa_fmt_pkg::BcdBits)'(0)};
          state_d  = StSkip;
        end else begin
          digits_d = {(64 - itoa_fmt_pkg::BcdBits)'(0), bcd_next};
        end
      end
      StSkip: begin
        // Drop one leading zero per cycle; a zero number keeps its last digit.
        if ((digits_q[63:60] == 4'd0) && !emit_last) begin
          digits_d = {digits_q[59:0], 4'b0};
          ndig_d   = ndig_q - CW'(1);
        end else begin
          total_d = ndig_q + CW'(sign_q);
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (sign_q) begin
            sign_d           = 1'b0;
            out_d.char_code  = itoa_fmt_pkg::AsciiMinus;
            out_d.last       = 1'b0;
            out_d.char_count = '0;
          end else begin
            out_d.char_code  = itoa_fmt_pkg::digit_char(digits_q[63:60], upper_q);
            out_d.last       = emit_last;
            out_d.char_count = emit_last ? total_q : '0;
            digits_d         = {digits_q[59:0], 4'b0};
            ndig_d           = ndig_q - CW'(1);
            if (emit_last) begin
              state_d = StIdle;
            end
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      sign_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      sign_q      <= sign_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    digits_q <= digits_d;
    bin_q    <= bin_d;
    cnt_q    <= cnt_d;
    ndig_q   <= ndig_d;
    total_q  <= total_d;
    upper_q  <= upper_d;
    out_q    <= out_d;
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

`ifndef SYNTHESIS
  // The sequencer is always in exactly one state.
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state is not one-hot");

  // The final character carries a nonzero count; earlier ones carry zero.
  a_last_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_req_o.last ? (out_req_o.char_count != '0)
                                    : (out_req_o.char_count == '0)))
    else $error("character count does not match the last flag");

  // The emitter always has at least one digit left and never more than sixteen.
  a_emit_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit) |-> ((ndig_q != '0) && (ndig_q <= CW'(16))))
    else $error("digit count out of range while emitting");

  // An unused mode is dropped without leaving idle.
  a_unused_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && (in_req_i.mode > itoa_fmt_pkg::ModePointerHex)) |=> (state_q == StIdle))
    else $error("unused mode started a conversion");
`endif

endmodule

### verif/tb_top.sv
// Self-checking testbench for the integer to ASCII formatter unit.
`timescale 1ns / 100ps

module tb_top;

  // Mode codes outside the defined set; the unit drops such requests.
  localparam logic [2:0] FirstUnusedMode = 3'd5;
  localparam logic [2:0] LastUnusedMode  = 3'd7;
  // Digit alphabets, character 0 in the top byte.
  localparam logic [0:15][7:0] LowerDigits = "0123456789abcdef";
  localparam logic [0:15][7:0] UpperDigits = "0123456789ABCDEF";
  // Random requests with a defined mode.
  localparam int unsigned RandomReqs = 140;
  // Cycles to wait after the last character; covers a full decimal conversion.
  localparam int unsigned DrainCycles = 80;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall_o;
  itoa_fmt_pkg::in_req_t  in_req = '0;
  logic                   out_valid_o;
  logic                   out_stall = 1'b0;
  itoa_fmt_pkg::out_req_t out_req_o;

  itoa_fmt_pkg::in_req_t  pending_reqs[$];
  itoa_fmt_pkg::out_req_t expected_chars[$];
  int unsigned            mismatch_cnt = 0;
  int unsigned            issued_cnt = 0;
  int unsigned            checked_cnt = 0;
  int unsigned            gap_left = 0;
  int unsigned            stall_left = 0;
  int unsigned            stall_draw;
  itoa_fmt_pkg::out_req_t want_char;

  integer_to_ascii_formatter_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_req_o   (out_req_o)
  );

  // Clock and a single reset pulse at the start.
  always #4 clk_i = ~clk_i;

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Prints one mismatch line and counts it.
  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_cnt++;
  endtask

  // Works out the characters that one number formats to and queues them.
  task automatic predict_text(input itoa_fmt_pkg::in_req_t req);
    logic [63:0]            mag;
    logic [31:0]            low_word;
    logic                   neg;
    logic                   upper;
    logic [63:0]            radix;
    logic [3:0]             digit;
    logic [6:0]             text[$];
    itoa_fmt_pkg::out_req_t ch;
    neg      = 1'b0;
    upper    = 1'b0;
    radix    = 64'd16;
    low_word = req.value[31:0];
    mag      = {32'd0, low_word};
    case (itoa_fmt_pkg::mode_e'(req.mode))
      itoa_fmt_pkg::ModeSignedDec: begin
        radix = 64'd10;
        if (low_word[31]) begin
          neg      = 1'b1;
          low_word = -low_word;
          mag      = {32'd0, low_word};
        end
      end
      itoa_fmt_pkg::ModeUnsignedDec: radix = 64'd10;
      itoa_fmt_pkg::ModeHexLower:    radix = 64'd16;
      itoa_fmt_pkg::ModeHexUpper:    upper = 1'b1;
      itoa_fmt_pkg::ModePointerHex:  mag = req.value & itoa_fmt_pkg::PtrMask;
      default:                       return;
    endcase

    // Peel off digits least significant first, so each goes to the front.
    do begin
      digit = 4'(mag % radix);
      text.push_front(upper ? UpperDigits[digit][6:0] : LowerDigits[digit][6:0]);
      mag = mag / radix;
    end while (mag != 0 && text.size() < 16);
    if (neg) text.push_front(itoa_fmt_pkg::AsciiMinus);

    foreach (text[i]) begin
      ch.char_code  = text[i];
      ch.last       = (i == text.size() - 1);
      ch.char_count = ch.last ? itoa_fmt_pkg::CountW'(text.size()) : '0;
      expected_chars.push_back(ch);
    end
  endtask

  // Request driver: holds each request until accepted, with random gaps in phases.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_req   <= '0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall_o) predict_text(in_req);
      if (!in_valid || !in_stall_o) begin
        if (gap_left != 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending_reqs.size() != 0) begin
          in_req   <= pending_reqs.pop_front();
          in_valid <= 1'b1;
          gap_left <= ((issued_cnt / 32) % 3 != 0) ? $urandom_range(0, 3) : 0;
          issued_cnt <= issued_cnt + 1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Character monitor: checks each accepted character and stalls at random.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid_o && !out_stall) begin
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected character %h", out_req_o.char_code));
      end else begin
        want_char = expected_chars.pop_front();
        if (out_req_o.char_code !== want_char.char_code)
          report_mismatch($sformatf("char_code got %h want %h",
                                    out_req_o.char_code, want_char.char_code));
        if (out_req_o.last !== want_char.last)
          report_mismatch($sformatf("last got %b want %b",
                                    out_req_o.last, want_char.last));
        if (out_req_o.char_count !== want_char.char_count)
          report_mismatch($sformatf("char_count got %0d want %0d",
                                    out_req_o.char_count, want_char.char_count));
      end
      checked_cnt <= checked_cnt + 1;
      stall_draw = ((checked_cnt / 100) % 3 != 1) ? $urandom_range(0, 3) : 0;
      out_stall  <= (stall_draw != 0);
      stall_left <= (stall_draw != 0) ? stall_draw - 1 : 0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Queues one request for the driver.
  task automatic queue_req(input logic [2:0] mode, input logic [63:0] value);
    itoa_fmt_pkg::in_req_t req;
    req.mode  = mode;
    req.value = value;
    pending_reqs.push_back(req);
  endtask

  // Stimulus: directed corner numbers, then random numbers of varied length.
  initial begin
    int unsigned defined_cnt;
    logic [2:0]  mode;
    logic [63:0] value;
    logic [63:0] pow10;

    // Signed decimal: zero, one, minus one, both extremes, ignored high bits.
    queue_req(itoa_fmt_pkg::ModeSignedDec, 64'd0);
    queue_req(itoa_fmt_pkg::ModeSignedDec, 64'd1);
    queue_req(itoa_fmt_pkg::ModeSignedDec, 64'h0000_0000_ffff_ffff);
    queue_req(itoa_fmt_pkg::ModeSignedDec, 64'h0000_0000_8000_0000);
    queue_req(itoa_fmt_pkg::ModeSignedDec, 64'hffff_ffff_7fff_ffff);
    queue_req(itoa_fmt_pkg::ModeSignedDec, 64'hdead_beef_0000_0123);
    // Unsigned decimal.
    queue_req(itoa_fmt_pkg::ModeUnsignedDec, 64'd0);
    queue_req(itoa_fmt_pkg::ModeUnsignedDec, 64'hffff_ffff_ffff_ffff);
    queue_req(itoa_fmt_pkg::ModeUnsignedDec, 64'd1000000000);
    queue_req(itoa_fmt_pkg::ModeUnsignedDec, 64'h1234_5678_0000_0009);
    // Hex in both cases.
    queue_req(itoa_fmt_pkg::ModeHexLower, 64'd0);
    queue_req(itoa_fmt_pkg::ModeHexLower, 64'h0000_0000_ffff_ffff);
    queue_req(itoa_fmt_pkg::ModeHexLower, 64'hffff_ffff_abcd_ef12);
    queue_req(itoa_fmt_pkg::ModeHexLower, 64'h10);
    queue_req(itoa_fmt_pkg::ModeHexUpper, 64'd0);
    queue_req(itoa_fmt_pkg::ModeHexUpper, 64'h5555_5555_ffff_ffff);
    queue_req(itoa_fmt_pkg::ModeHexUpper, 64'h0000_0000_0000_abcd);
    // Pointer hex over the full width.
    queue_req(itoa_fmt_pkg::ModePointerHex, 64'd0);
    queue_req(itoa_fmt_pkg::ModePointerHex, 64'hffff_ffff_ffff_ffff);
    queue_req(itoa_fmt_pkg::ModePointerHex, 64'h8000_0000_0000_0000);
    queue_req(itoa_fmt_pkg::ModePointerHex, 64'h0123_4567_89ab_cdef);
    // Unused modes produce nothing.
    queue_req(FirstUnusedMode, {$urandom, $urandom});
    queue_req(FirstUnusedMode + 3'd1, {$urandom, $urandom});
    queue_req(LastUnusedMode, 64'hffff_ffff_ffff_ffff);

    defined_cnt = 0;
    while (defined_cnt < RandomReqs) begin
      if ($urandom_range(0, 19) == 0) begin
        mode = 3'($urandom_range(FirstUnusedMode, LastUnusedMode));
      end else begin
        mode = 3'($urandom_range(itoa_fmt_pkg::ModeSignedDec, itoa_fmt_pkg::ModePointerHex));
        defined_cnt++;
      end
      value = {$urandom, $urandom};
      case ($urandom_range(0, 3))
        // Fewer significant bits, for short texts.
        0: value = value >> $urandom_range(0, 63);
        // Just around a power of ten.
        1: begin
          pow10 = 64'd1;
          repeat ($urandom_range(0, 9)) pow10 = pow10 * 64'd10;
          value = pow10 - 64'($urandom_range(0, 1));
        end
        // Small negative numbers in two's complement.
        2: value = 64'hffff_ffff_ffff_ffff - 64'($urandom_range(0, 1000));
        default: ;
      endcase
      queue_req(mode, value);
    end

    // Drain: all requests accepted, all characters seen, then a quiet spell.
    @(posedge rst_ni);
    while (pending_reqs.size() != 0 || in_valid) @(posedge clk_i);
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

### sim.f
src/itoa_fmt_pkg.sv
src/integer_to_ascii_formatter_unit.sv
verif/tb_top.sv
